@@ rtl/tnts_pkg.sv @@
package tnts_pkg;

   // Item op codes
   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_NOTE   = 3'd1;
   localparam logic [2:0] OP_VOLUME = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_TONE_CLOCK_HZ     = 2'd0;
   localparam logic [1:0] CSR_TIMER_HZ          = 2'd1;
   localparam logic [1:0] CSR_TEMPO_BPM         = 2'd2;
   localparam logic [1:0] CSR_TICKS_PER_QUARTER = 2'd3;

   localparam int CsrDataWidth = 28;

   // Register reset values
   localparam logic [25:0] TONE_CLOCK_RESET = 26'd6250000;
   localparam logic [27:0] TIMER_HZ_RESET   = 28'd100000000;
   localparam logic [9:0]  TEMPO_RESET      = 10'd120;
   localparam logic [15:0] TPQ_RESET        = 16'd480;

   // Full-scale volume and the duty divisor (twice full scale)
   localparam logic [11:0] VOL_FULL    = 12'd4095;
   localparam logic [25:0] DUTY_DIVISOR = 26'd8190;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] pitch_hz;
      logic [15:0] note_ticks;
      logic [11:0] volume_sample;
   } req_type;

   typedef struct packed {
      logic [25:0] pwm_period;
      logic [24:0] pwm_duty;
      logic        sounding;
      logic        note_done;
      logic        stopped;
   } rsp_type;

endpackage

@@ rtl/tempo_note_tone_sequencer_core.sv @@
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------
// req      | in        | req_valid / req_ready | req_data (tnts_pkg::req_type)
// rsp      | out       | rsp_valid / rsp_ready | rsp_data (tnts_pkg::rsp_type)
// csr      | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One transaction in flight; each request yields one response, and req_ready returns
// with it. Start, stop, tick, unknown ops, ignored notes and silent volume respond
// directly; volume while sounding runs the duty steps; a rest, the duration multiplies
// and division; a tone note, the period division, the duty steps for a nonzero period,
// then the duration. The divider makes 27 or 50 quotient bits, one per cycle. Reset is
// synchronous; csr_ready is always high. A held response stalls the last step.
module tempo_note_tone_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tnts_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tnts_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [tnts_pkg::CsrDataWidth-1:0]   csr_data
);

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV_LOAD = 4'd1;
   localparam logic [3:0] S_DIV      = 4'd2;
   localparam logic [3:0] S_MUL_DUTY = 4'd3;
   localparam logic [3:0] S_MUL_DEN  = 4'd4;
   localparam logic [3:0] S_MUL_NUM  = 4'd5;
   localparam logic [3:0] S_FINISH   = 4'd6;
   localparam logic [3:0] S_DUTY_EST = 4'd7;
   localparam logic [3:0] S_DUTY_FIX = 4'd8;

   // Division kinds
   localparam logic [1:0] DK_PERIOD   = 2'd0;
   localparam logic [1:0] DK_DURATION = 2'd1;

   // Quotient bits per division kind
   localparam logic [5:0] PERIOD_BITS   = 6'd27;
   localparam logic [5:0] DURATION_BITS = 6'd50;

   // Configuration registers
   logic [25:0] tone_clock_ff, tone_clock_in;
   logic [27:0] timer_hz_ff, timer_hz_in;
   logic [9:0]  tempo_ff, tempo_in;
   logic [15:0] tpq_ff, tpq_in;

   // Sequencer state
   logic [25:0] tone_period_ff, tone_period_in;
   logic [24:0] tone_duty_ff, tone_duty_in;
   logic [11:0] latest_volume_ff, latest_volume_in;
   logic [31:0] ticks_ff, ticks_in;
   logic        tone_on_ff, tone_on_in;
   logic        pending_ff, pending_in;
   logic        stop_ff, stop_in;
   logic        done_ff, done_in;

   // Control
   logic [3:0]  state_ff, state_in;
   logic [1:0]  div_kind_ff, div_kind_in;
   logic [2:0]  op_ff, op_in;
   logic [15:0] freq_ff, freq_in;
   logic [15:0] nt_ff, nt_in;

   // Shared multiplier and divider
   logic [33:0] mul_a;
   logic [15:0] mul_b;
   logic [49:0] mul_prod;
   logic [49:0] prod_ff, prod_in;
   logic [25:0] den_ff, den_in;
   logic [49:0] div_q_ff, div_q_in;
   logic [25:0] div_r_ff, div_r_in;
   logic [25:0] div_d_ff, div_d_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   tnts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Helper signals
   logic        req_fire;
   logic        out_free;
   logic [26:0] div_r_ext;
   logic        div_ge;
   logic [26:0] per_num;
   logic [9:0]  tempo_eff;
   logic [15:0] tpq_eff;
   logic [33:0] timer60;
   logic [31:0] tick_next;
   logic [31:0] dur_sat;
   logic [36:0] duty_half;
   logic [37:0] duty_sum;
   logic [37:0] duty_rem;
   logic        duty_fix;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Operand preparation
   assign per_num   = {1'b0, tone_clock_ff} + {12'd0, freq_ff[15:1]};
   assign tempo_eff = (tempo_ff == 10'd0) ? 10'd1 : tempo_ff;
   assign tpq_eff   = (tpq_ff == 16'd0) ? 16'd1 : tpq_ff;
   assign timer60   = {timer_hz_ff, 6'd0} - {4'd0, timer_hz_ff, 2'd0};
   assign tick_next = ticks_ff - {31'd0, (ticks_ff != 32'd0)};

   // Divider step: shift one dividend bit into the remainder, subtract if it fits
   assign div_r_ext = {div_r_ff, div_q_ff[49]};
   assign div_ge    = (div_r_ext >= {1'b0, div_d_ff});

   // Saturate the duration quotient to 32 bits
   assign dur_sat = (div_q_ff[49:32] != 18'd0) ? 32'hFFFF_FFFF : div_q_ff[31:0];

   // Duty divide by 8190: halve, then divide by 4095 as a sum of 12-bit shifts;
   // the estimate is the quotient or one short, and one compare settles it
   assign duty_half = prod_ff[37:1];
   assign duty_sum  = {1'b0, duty_half} + {13'd0, duty_half[36:12]}
                    + {25'd0, duty_half[36:24]} + {37'd0, duty_half[36]};
   assign duty_rem  = prod_ff[37:0] - {div_q_ff[24:0], 13'd0}
                    + {12'd0, div_q_ff[24:0], 1'b0};
   assign duty_fix  = (duty_rem >= {12'd0, tnts_pkg::DUTY_DIVISOR});

   // Select multiplier operands per step
   always_comb begin
      unique case (state_ff)
         S_MUL_DUTY: begin
            mul_a = {8'd0, tone_period_ff};
            mul_b = {4'd0, latest_volume_ff};
         end
         S_MUL_DEN: begin
            mul_a = {24'd0, tempo_eff};
            mul_b = tpq_eff;
         end
         default: begin
            mul_a = timer60;
            mul_b = nt_ff;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // Next-state logic
   always_comb begin
      tone_clock_in    = tone_clock_ff;
      timer_hz_in      = timer_hz_ff;
      tempo_in         = tempo_ff;
      tpq_in           = tpq_ff;
      tone_period_in   = tone_period_ff;
      tone_duty_in     = tone_duty_ff;
      latest_volume_in = latest_volume_ff;
      ticks_in         = ticks_ff;
      tone_on_in       = tone_on_ff;
      pending_in       = pending_ff;
      stop_in          = stop_ff;
      done_in          = done_ff;
      state_in         = state_ff;
      div_kind_in      = div_kind_ff;
      op_in            = op_ff;
      freq_in          = freq_ff;
      nt_in            = nt_ff;
      prod_in          = prod_ff;
      den_in           = den_ff;
      div_q_in         = div_q_ff;
      div_r_in         = div_r_ff;
      div_d_in         = div_d_ff;
      div_cnt_in       = div_cnt_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Write configuration registers
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tnts_pkg::CSR_TONE_CLOCK_HZ:     tone_clock_in = csr_data[25:0];
            tnts_pkg::CSR_TIMER_HZ:          timer_hz_in   = csr_data[27:0];
            tnts_pkg::CSR_TEMPO_BPM:         tempo_in      = csr_data[9:0];
            tnts_pkg::CSR_TICKS_PER_QUARTER: tpq_in        = csr_data[15:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_data.op;
               freq_in = req_data.pitch_hz;
               nt_in   = req_data.note_ticks;
               done_in = 1'b0;
               state_in = S_FINISH;
               if (req_data.op == tnts_pkg::OP_START || req_data.op == tnts_pkg::OP_STOP) begin
                  stop_in      = (req_data.op == tnts_pkg::OP_STOP);
                  tone_on_in   = 1'b0;
                  tone_duty_in = 25'd0;
                  pending_in   = 1'b0;
                  ticks_in     = 32'd0;
               end else if (req_data.op == tnts_pkg::OP_NOTE) begin
                  if (!stop_ff) begin
                     if (req_data.pitch_hz == 16'd0) begin
                        tone_on_in   = 1'b0;
                        tone_duty_in = 25'd0;
                        state_in     = S_MUL_DEN;
                     end else begin
                        div_kind_in = DK_PERIOD;
                        state_in    = S_DIV_LOAD;
                     end
                  end
               end else if (req_data.op == tnts_pkg::OP_VOLUME) begin
                  latest_volume_in = req_data.volume_sample;
                  if (tone_on_ff) begin
                     state_in = S_MUL_DUTY;
                  end
               end else if (req_data.op == tnts_pkg::OP_TICK) begin
                  if (pending_ff) begin
                     ticks_in = tick_next;
                     if (tick_next == 32'd0) begin
                        pending_in = 1'b0;
                        done_in    = 1'b1;
                     end
                  end
               end
            end
         end

         S_DIV_LOAD: begin
            // Left-align the dividend so the quotient lands in the low bits
            div_r_in = 26'd0;
            state_in = S_DIV;
            unique case (div_kind_ff)
               DK_PERIOD: begin
                  div_q_in   = {per_num, 23'd0};
                  div_d_in   = {10'd0, freq_ff};
                  div_cnt_in = PERIOD_BITS;
               end
               default: begin
                  div_q_in   = prod_ff;
                  div_d_in   = den_ff;
                  div_cnt_in = DURATION_BITS;
               end
            endcase
         end

         S_DIV: begin
            div_r_in   = div_ge ? 26'(div_r_ext - {1'b0, div_d_ff}) : div_r_ext[25:0];
            div_q_in   = {div_q_ff[48:0], div_ge};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd0) begin
               // Quotient complete: dispatch on what it was for
               div_r_in   = div_r_ff;
               div_q_in   = div_q_ff;
               div_cnt_in = div_cnt_ff;
               unique case (div_kind_ff)
                  DK_PERIOD: begin
                     tone_period_in = div_q_ff[25:0];
                     if (div_q_ff[25:0] != 26'd0) begin
                        tone_on_in = 1'b1;
                        state_in   = S_MUL_DUTY;
                     end else begin
                        tone_on_in   = 1'b0;
                        tone_duty_in = 25'd0;
                        state_in     = S_MUL_DEN;
                     end
                  end
                  default: begin
                     ticks_in   = dur_sat;
                     pending_in = (dur_sat != 32'd0);
                     done_in    = (dur_sat == 32'd0);
                     state_in   = S_FINISH;
                  end
               endcase
            end
         end

         S_MUL_DUTY: begin
            prod_in  = mul_prod;
            state_in = S_DUTY_EST;
         end

         S_DUTY_EST: begin
            div_q_in = {25'd0, duty_sum[36:12]};
            state_in = S_DUTY_FIX;
         end

         S_DUTY_FIX: begin
            tone_duty_in = div_q_ff[24:0] + {24'd0, duty_fix};
            state_in = (op_ff == tnts_pkg::OP_NOTE) ? S_MUL_DEN : S_FINISH;
         end

         S_MUL_DEN: begin
            prod_in  = mul_prod;
            state_in = S_MUL_NUM;
         end

         S_MUL_NUM: begin
            den_in      = prod_ff[25:0];
            prod_in     = mul_prod;
            div_kind_in = DK_DURATION;
            state_in    = S_DIV_LOAD;
         end

         S_FINISH: begin
            // Hold until the response slot is free
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pwm_period  = tone_period_ff;
               rsp_data_in.pwm_duty    = tone_on_ff ? tone_duty_ff : 25'd0;
               rsp_data_in.sounding    = tone_on_ff;
               rsp_data_in.note_done   = done_ff;
               rsp_data_in.stopped     = stop_ff;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_clock_ff    <= tnts_pkg::TONE_CLOCK_RESET;
         timer_hz_ff      <= tnts_pkg::TIMER_HZ_RESET;
         tempo_ff         <= tnts_pkg::TEMPO_RESET;
         tpq_ff           <= tnts_pkg::TPQ_RESET;
         tone_period_ff   <= 26'd0;
         tone_duty_ff     <= 25'd0;
         latest_volume_ff <= tnts_pkg::VOL_FULL;
         ticks_ff         <= 32'd0;
         tone_on_ff       <= 1'b0;
         pending_ff       <= 1'b0;
         stop_ff          <= 1'b0;
         done_ff          <= 1'b0;
         state_ff         <= S_IDLE;
         div_kind_ff      <= DK_PERIOD;
         rsp_valid_ff     <= 1'b0;
      end else begin
         tone_clock_ff    <= tone_clock_in;
         timer_hz_ff      <= timer_hz_in;
         tempo_ff         <= tempo_in;
         tpq_ff           <= tpq_in;
         tone_period_ff   <= tone_period_in;
         tone_duty_ff     <= tone_duty_in;
         latest_volume_ff <= latest_volume_in;
         ticks_ff         <= ticks_in;
         tone_on_ff       <= tone_on_in;
         pending_ff       <= pending_in;
         stop_ff          <= stop_in;
         done_ff          <= done_in;
         state_ff         <= state_in;
         div_kind_ff      <= div_kind_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      freq_ff     <= freq_in;
      nt_ff       <= nt_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ test/tempo_note_tone_sequencer_core_tb.sv @@
module tempo_note_tone_sequencer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [tnts_pkg::CsrDataWidth-1:0] csr_word_type;

   // Ops outside the defined set, used to check that the state is left alone
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   localparam longint unsigned SECONDS_PER_MINUTE = 64'd60;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   tnts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tnts_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   csr_word_type csr_data = '0;

   // Register copies kept by the tone predictor
   logic [25:0] clk_cfg = tnts_pkg::TONE_CLOCK_RESET;
   logic [27:0] timer_cfg = tnts_pkg::TIMER_HZ_RESET;
   logic [9:0] bpm_cfg = tnts_pkg::TEMPO_RESET;
   logic [15:0] tpq_cfg = tnts_pkg::TPQ_RESET;

   // Sequencer state kept by the tone predictor
   logic [25:0] cur_period = '0;
   logic [24:0] cur_duty = '0;
   logic [11:0] last_volume = tnts_pkg::VOL_FULL;
   logic [31:0] ticks_left = '0;
   logic tone_active = 1'b0;
   logic note_armed = 1'b0;
   logic halted = 1'b0;

   tnts_pkg::rsp_type expected_tones[$];
   int mismatch_count = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;

   tempo_note_tone_sequencer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // Stall the response side at random unless idling is switched off
   always @(negedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= 12);
   end

   // High time for a period at a given volume, half the period at full scale
   function automatic logic [24:0] duty_for(logic [25:0] period, logic [11:0] vol);
      longint unsigned wide;
      wide = (64'(period) * 64'(vol)) / 64'(tnts_pkg::DUTY_DIVISOR);
      return wide[24:0];
   endfunction

   // Timer ticks for a note length, saturated to 32 bits
   function automatic logic [31:0] ticks_for(logic [15:0] score);
      longint unsigned bpm;
      longint unsigned per_quarter;
      longint unsigned wide;
      bpm = (bpm_cfg == 0) ? 64'd1 : 64'(bpm_cfg);
      per_quarter = (tpq_cfg == 0) ? 64'd1 : 64'(tpq_cfg);
      wide = 64'(timer_cfg) * SECONDS_PER_MINUTE * 64'(score);
      wide = wide / (bpm * per_quarter);
      return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
   endfunction

   // Advance the predicted sequencer by one event and return its response
   function automatic tnts_pkg::rsp_type advance_sequencer(tnts_pkg::req_type item);
      tnts_pkg::rsp_type res;
      logic finished;
      longint unsigned wide;
      finished = 1'b0;
      unique case (item.op)
         tnts_pkg::OP_START: begin
            halted = 1'b0;
            tone_active = 1'b0;
            cur_duty = '0;
            note_armed = 1'b0;
            ticks_left = '0;
         end
         tnts_pkg::OP_NOTE: begin
            if (!halted) begin
               if (item.pitch_hz == 0) begin
                  tone_active = 1'b0;
                  cur_duty = '0;
               end else begin
                  wide = (64'(clk_cfg) + 64'(item.pitch_hz >> 1)) /
                         64'(item.pitch_hz);
                  cur_period = wide[25:0];
                  if (cur_period != 0) begin
                     tone_active = 1'b1;
                     cur_duty = duty_for(cur_period, last_volume);
                  end else begin
                     tone_active = 1'b0;
                     cur_duty = '0;
                  end
               end
               ticks_left = ticks_for(item.note_ticks);
               note_armed = (ticks_left != 0);
               finished = (ticks_left == 0);
            end
         end
         tnts_pkg::OP_VOLUME: begin
            last_volume = item.volume_sample;
            if (tone_active) cur_duty = duty_for(cur_period, last_volume);
         end
         tnts_pkg::OP_TICK: begin
            if (note_armed) begin
               if (ticks_left != 0) ticks_left = ticks_left - 1;
               if (ticks_left == 0) begin
                  note_armed = 1'b0;
                  finished = 1'b1;
               end
            end
         end
         tnts_pkg::OP_STOP: begin
            halted = 1'b1;
            tone_active = 1'b0;
            cur_duty = '0;
            note_armed = 1'b0;
            ticks_left = '0;
         end
         default: begin
         end
      endcase
      res.pwm_period = cur_period;
      res.pwm_duty = tone_active ? cur_duty : '0;
      res.sounding = tone_active;
      res.note_done = finished;
      res.stopped = halted;
      return res;
   endfunction

   function automatic tnts_pkg::req_type event_item(logic [2:0] op, logic [15:0] freq,
                                                    logic [15:0] score, logic [11:0] vol);
      tnts_pkg::req_type item;
      item.op = op;
      item.pitch_hz = freq;
      item.note_ticks = score;
      item.volume_sample = vol;
      return item;
   endfunction

   // Random content in every field, op forced
   function automatic tnts_pkg::req_type random_item(logic [2:0] op);
      tnts_pkg::req_type item;
      item.op = op;
      item.pitch_hz = 16'($urandom());
      item.note_ticks = 16'($urandom());
      item.volume_sample = 12'($urandom());
      return item;
   endfunction

   function automatic void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   // Check each response transaction against the oldest expectation
   always @(posedge clock) begin
      tnts_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tones.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_tones.pop_front();
            compare_field("pwm_period", want.pwm_period, rsp_data.pwm_period);
            compare_field("pwm_duty", want.pwm_duty, rsp_data.pwm_duty);
            compare_field("sounding", want.sounding, rsp_data.sounding);
            compare_field("note_done", want.note_done, rsp_data.note_done);
            compare_field("stopped", want.stopped, rsp_data.stopped);
         end
      end
   end

   // Count cycles in which no channel moves a transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Send one event; enter and leave at a falling edge, valid left high
   task automatic send_event(tnts_pkg::req_type item);
      if (idle_on && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 12);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_tones.push_back(advance_sequencer(item));
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the sender until every expected response has arrived
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (expected_tones.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] reg_index, csr_word_type value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (reg_index)
         tnts_pkg::CSR_TONE_CLOCK_HZ: clk_cfg = value[25:0];
         tnts_pkg::CSR_TIMER_HZ: timer_cfg = value[27:0];
         tnts_pkg::CSR_TEMPO_BPM: bpm_cfg = value[9:0];
         tnts_pkg::CSR_TICKS_PER_QUARTER: tpq_cfg = value[15:0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // Drain, then rewrite all four registers
   task automatic program_regs(int unsigned tone_clk, int unsigned tick_rate,
                               int unsigned bpm, int unsigned per_quarter);
      wait_for_quiet();
      write_reg(tnts_pkg::CSR_TONE_CLOCK_HZ, csr_word_type'(tone_clk));
      write_reg(tnts_pkg::CSR_TIMER_HZ, csr_word_type'(tick_rate));
      write_reg(tnts_pkg::CSR_TEMPO_BPM, csr_word_type'(bpm));
      write_reg(tnts_pkg::CSR_TICKS_PER_QUARTER, csr_word_type'(per_quarter));
      csr_valid <= 1'b0;
   endtask

   // Every op under the reset register values, stop and unknown ops included
   task automatic test_reset_defaults();
      send_event(event_item(tnts_pkg::OP_START, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd440, 16'd0, '0));
      send_event(event_item(tnts_pkg::OP_VOLUME, '0, '0, 12'd0));
      send_event(event_item(tnts_pkg::OP_VOLUME, '0, '0, 12'hFFF));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'hFFFF, 16'hFFFF, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd0, 16'd1, '0));
      send_event(event_item(OP_UNUSED_LO, '1, '1, '1));
      send_event(event_item(OP_UNUSED_HI, '1, '1, '1));
      send_event(event_item(tnts_pkg::OP_STOP, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd1000, 16'd0, '0));
      send_event(event_item(tnts_pkg::OP_VOLUME, '0, '0, 12'd100));
      send_event(event_item(tnts_pkg::OP_START, '0, '0, '0));
      wait_for_quiet();
   endtask

   // Register extremes: zero tempo and quarter, periods at both ends, saturation
   task automatic test_register_extremes();
      program_regs(1, 1, 0, 0);
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd3, 16'd1, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd1, 16'd0, '0));
      program_regs(26'h3FF_FFFF, 28'hFFF_FFFF, 1023, 65535);
      send_event(event_item(tnts_pkg::OP_VOLUME, '0, '0, 12'hFFF));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd1, 16'hFFFF, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd2, 16'd1, '0));
      program_regs(26'h3FF_FFFF, 28'hFFF_FFFF, 1, 1);
      send_event(event_item(tnts_pkg::OP_NOTE, 16'hFFFF, 16'hFFFF, '0));
      send_event(event_item(tnts_pkg::OP_VOLUME, '0, '0, 12'd0));
      wait_for_quiet();
   endtask

   // Short notes: countdown to done, extra tick, replaced note, timed rest
   task automatic test_note_countdown();
      program_regs(6250000, 100, 120, 480);
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd880, 16'd20, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd440, 16'd30, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd660, 16'd10, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      send_event(event_item(tnts_pkg::OP_NOTE, 16'd0, 16'd10, '0));
      send_event(event_item(tnts_pkg::OP_TICK, '0, '0, '0));
      wait_for_quiet();
   endtask

   // One song: start, volume, notes ticked out (some cut short), maybe a stop
   task automatic play_song(int unsigned per_tick);
      tnts_pkg::req_type item;
      int unsigned notes;
      int unsigned tick_limit;
      int unsigned ticks_sent;
      send_event(random_item(tnts_pkg::OP_START));
      send_event(random_item(tnts_pkg::OP_VOLUME));
      notes = $urandom_range(1, 6);
      repeat (notes) begin
         item = random_item(tnts_pkg::OP_NOTE);
         if ($urandom_range(9) == 0) item.pitch_hz = '0;
         if ($urandom_range(7) != 0) item.note_ticks = 16'($urandom_range(0, per_tick * 6));
         send_event(item);
         tick_limit = ($urandom_range(4) == 0) ? $urandom_range(0, 2) : 40;
         ticks_sent = 0;
         while (note_armed && ticks_sent < tick_limit) begin
            if ($urandom_range(9) == 0) send_event(random_item(tnts_pkg::OP_VOLUME));
            else send_event(random_item(tnts_pkg::OP_TICK));
            ticks_sent++;
         end
      end
      if ($urandom_range(2) == 0) begin
         send_event(random_item(tnts_pkg::OP_STOP));
         send_event(random_item(tnts_pkg::OP_NOTE));
         send_event(random_item(tnts_pkg::OP_TICK));
      end
      if ($urandom_range(9) == 0) wait_for_quiet();
   endtask

   // Random songs and noise over several register settings
   task automatic test_random_songs();
      int unsigned bpm;
      int unsigned per_quarter;
      int unsigned per_tick;
      int unsigned tone_clk;
      int unsigned tick_rate;
      int phase_end;
      for (int phase = 0; phase < 8; phase++) begin
         bpm = $urandom_range(1, 1023);
         per_quarter = ($urandom_range(3) == 0) ? $urandom_range(1, 65535)
                                                : $urandom_range(24, 960);
         per_tick = $urandom_range(1, 32);
         tone_clk = ($urandom_range(3) == 0) ? $urandom_range(1, 200000)
                                             : $urandom_range(1000000, 67108863);
         // pick the timer rate so a typical note lasts a handful of ticks
         tick_rate = (bpm * per_quarter) / (60 * per_tick);
         if (tick_rate == 0) tick_rate = 1;
         program_regs(tone_clk, tick_rate, bpm, per_quarter);
         idle_on = (phase != 3);
         phase_end = items_sent + 155;
         while (items_sent < phase_end) begin
            if ($urandom_range(9) == 0) send_event(random_item(3'($urandom_range(0, 7))));
            else play_song(per_tick);
         end
      end
      idle_on = 1'b1;
      wait_for_quiet();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_note_countdown();
      test_random_songs();
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
